/* rtl/sha256_byte_stream_hasher_top_defines.svh */
// Assertion macros used by the hasher core.
`ifndef SHA256_BYTE_STREAM_HASHER_TOP_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_TOP_DEFINES_SVH
// Clocked implication, held off while reset is asserted.
`define SHB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define SHB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

/* rtl/shb_pkg.sv */
// Package with SHA-256 constants, types and round functions.
`default_nettype none
package shb_pkg;
	localparam int QDEPTH = 4;
	localparam int QAW = 2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic byte_present;
		logic last_byte;
	} shb_item_t;

	typedef struct packed {
		logic [63:0] digest_word;
		logic [1:0] word_index;
		logic last_word;
	} shb_result_t;

	localparam logic [255:0] INIT_HASH = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	function automatic logic [31:0] round_k(input logic [5:0] r);
		logic [31:0] k;
		unique case (r)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction
endpackage
`default_nettype wire

/* rtl/shb_stream_if.sv */
// Valid/ready channel interfaces for input items and digest results.
`default_nettype none
interface shb_in_if import shb_pkg::*; ();
	logic valid;
	logic ready;
	logic [7:0] data_byte;
	logic byte_present;
	logic last_byte;
	modport source(output valid, data_byte, byte_present, last_byte, input ready);
	modport sink(input valid, data_byte, byte_present, last_byte, output ready);
endinterface

interface shb_out_if import shb_pkg::*; ();
	logic valid;
	logic ready;
	logic [63:0] digest_word;
	logic [1:0] word_index;
	logic last_word;
	modport source(output valid, digest_word, word_index, last_word, input ready);
	modport sink(input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

/* rtl/sha256_byte_stream_hasher_top.sv */
// Top level of the SHA-256 byte-stream hasher.
// A byte is packed when the core takes it from the queue; the byte that fills a block starts
// compression (load, 64 rounds, chaining add), and no byte is taken until the add is done.
// The final item adds a pad block, a second one when the length does not fit, and
// four result beats. The round unit, one round per cycle, sets the throughput.
// Reset (arst_n low, asynchronous) restores the initial hash and empties the queue.
`default_nettype none
module sha256_byte_stream_hasher_top import shb_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	shb_in_if.sink in_ch,
	shb_out_if.source out_ch
);
	shb_item_t item;
	logic item_valid;
	logic item_take;

	// The front queue absorbs items while the core compresses.
	shb_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.item(item), .item_valid(item_valid), .item_take(item_take));

	// The core runs padding, rounds and the digest output.
	shb_core u_core (
		.clk(clk), .arst_n(arst_n), .item(item), .item_valid(item_valid),
		.item_take(item_take), .out_ch(out_ch));
endmodule
`default_nettype wire

/* rtl/shb_front.sv */
// Front end: accepts items, drops idle ones, queues the rest for the core.
`default_nettype none
module shb_front import shb_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	shb_in_if.sink in_ch,
	output shb_item_t item,
	output logic item_valid,
	input wire logic item_take
);
	shb_item_t mem_q [QDEPTH];
	logic [QAW-1:0] wr_q, rd_q;
	logic [QAW:0] cnt_q;
	logic push, pop;

	assign in_ch.ready = (cnt_q != QDEPTH[QAW:0]);
	// Idle items carry no work and are dropped on entry.
	assign push = in_ch.valid && in_ch.ready && (in_ch.byte_present || in_ch.last_byte);
	assign item_valid = (cnt_q != '0);
	assign pop = item_valid && item_take;
	assign item = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= '{in_ch.data_byte, in_ch.byte_present, in_ch.last_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + {{QAW{1'b0}}, push} - {{QAW{1'b0}}, pop};
		end
	end
endmodule
`default_nettype wire

/* rtl/shb_core.sv */
// Back end: byte packing, padding, 64-round compression and digest output.
`default_nettype none
`include "sha256_byte_stream_hasher_top_defines.svh"
module shb_core import shb_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input shb_item_t item,
	input wire logic item_valid,
	output logic item_take,
	shb_out_if.source out_ch
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PAD = 3'd1;
	localparam logic [2:0] ST_RND = 3'd2;
	localparam logic [2:0] ST_ADD = 3'd3;
	localparam logic [2:0] ST_LEN = 3'd4;
	localparam logic [2:0] ST_OUT = 3'd5;

	logic [2:0] st_q;
	logic [31:0] w_q [16];
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [28:0] cnt_q;
	logic [6:0] rnd_q;
	logic fin_q;   // block being compressed ends the message
	logic len_q;   // a length-only block still follows
	logic [1:0] oi_q;

	logic [5:0] pos;
	logic [31:0] s0, s1, wn, t1, t2, wcur, wm2, wm15;
	logic [5:0] r6;

	assign pos = cnt_q[5:0];
	assign r6 = rnd_q[5:0];
	assign wm2 = w_q[4'(r6 - 6'd2)];
	assign wm15 = w_q[4'(r6 - 6'd15)];
	assign s1 = rotr(wm2, 17) ^ rotr(wm2, 19) ^ (wm2 >> 10);
	assign s0 = rotr(wm15, 7) ^ rotr(wm15, 18) ^ (wm15 >> 3);
	assign wn = s1 + w_q[4'(r6 - 6'd7)] + s0 + w_q[r6[3:0]];
	assign wcur = (r6 < 6'd16) ? w_q[r6[3:0]] : wn;
	assign t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
		+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + round_k(r6) + wcur;
	assign t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
		+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

	assign item_take = (st_q == ST_IDLE) && item_valid;
	assign out_ch.valid = (st_q == ST_OUT);
	assign out_ch.digest_word = {h_q[{oi_q, 1'b0}], h_q[{oi_q, 1'b1}]};
	assign out_ch.word_index = oi_q;
	assign out_ch.last_word = (oi_q == 2'd3);

	function automatic logic [31:0] put(input logic [31:0] w, input logic [1:0] b,
		input logic [7:0] v);
		logic [31:0] r;
		r = w;
		r[(5'd24 - {b, 3'b000}) +: 8] = v;
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			cnt_q <= '0;
			rnd_q <= '0;
			fin_q <= 1'b0;
			len_q <= 1'b0;
			oi_q <= '0;
			for (int i = 0; i < 16; i++) w_q[i] <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= INIT_HASH[255 - 32*i -: 32];
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (item_valid) begin
						if (item.byte_present) begin
							w_q[pos[5:2]] <= put(w_q[pos[5:2]], pos[1:0], item.data_byte);
							cnt_q <= cnt_q + 1'b1;
							if (pos == 6'd63) begin
								fin_q <= 1'b0;
								len_q <= item.last_byte;
								st_q <= ST_RND;
								rnd_q <= '0;
								for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
							end else if (item.last_byte) begin
								st_q <= ST_PAD;
							end
						end else begin
							st_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					// Mark byte, then length if it fits in this block.
					w_q[pos[5:2]] <= put(w_q[pos[5:2]], pos[1:0], 8'h80);
					if (pos < 6'd56) begin
						w_q[14] <= '0;
						w_q[15] <= {cnt_q, 3'b000};
						fin_q <= 1'b1;
						len_q <= 1'b0;
					end else begin
						fin_q <= 1'b0;
						len_q <= 1'b1;
					end
					rnd_q <= '0;
					for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
					st_q <= ST_RND;
				end
				ST_RND: begin
					if (r6 >= 6'd16) w_q[r6[3:0]] <= wn;
					v_q[7] <= v_q[6];
					v_q[6] <= v_q[5];
					v_q[5] <= v_q[4];
					v_q[4] <= v_q[3] + t1;
					v_q[3] <= v_q[2];
					v_q[2] <= v_q[1];
					v_q[1] <= v_q[0];
					v_q[0] <= t1 + t2;
					rnd_q <= rnd_q + 1'b1;
					if (r6 == 6'd63) st_q <= ST_ADD;
				end
				ST_ADD: begin
					rnd_q <= '0;
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					for (int i = 0; i < 16; i++) w_q[i] <= '0;
					if (fin_q) begin
						oi_q <= '0;
						st_q <= ST_OUT;
					end else if (len_q) begin
						st_q <= ST_LEN;
					end else begin
						st_q <= ST_IDLE;
					end
				end
				ST_LEN: begin
					// Block with only the length; mark byte already placed or
					// at position zero when the message filled a block exactly.
					if (pos == 6'd0) w_q[0] <= 32'h80000000;
					w_q[14] <= '0;
					w_q[15] <= {cnt_q, 3'b000};
					fin_q <= 1'b1;
					len_q <= 1'b0;
					rnd_q <= '0;
					for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
					st_q <= ST_RND;
				end
				ST_OUT: begin
					if (out_ch.ready) begin
						oi_q <= oi_q + 1'b1;
						if (oi_q == 2'd3) begin
							for (int i = 0; i < 8; i++) h_q[i] <= INIT_HASH[255 - 32*i -: 32];
							cnt_q <= '0;
							st_q <= ST_IDLE;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	`SHB_ASSERT_IMPL(a_rnd_range, clk, arst_n, st_q == ST_RND, rnd_q < 7'd64, "round count out of range")
	`SHB_ASSERT_IMPL(a_take_idle, clk, arst_n, item_take, st_q == ST_IDLE, "item taken while busy")
	`SHB_ASSERT_NEXT(a_out_hold, clk, arst_n, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(oi_q), "digest chunk dropped")
endmodule
`default_nettype wire
